### hdl/bpgb_pkg.sv
// Shared types and constants for the box pair Gaussian bounds block.
// No dependencies; imported by bpgb_acc and box_pair_gaussian_bounds_top.
`timescale 1ns / 1ps

package bpgb_pkg;

  localparam int OUT_W      = 48;
  localparam int WEIGHT_W   = 16;
  localparam int TERM_SHIFT = 24;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ_GO,
    S_SQ_RUN,
    S_WT_GO,
    S_WT_RUN,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    TERM_BEST,
    TERM_WORST,
    TERM_MIXED
  } term_t;

  typedef struct packed {
    logic  upd;
    term_t sel;
    logic  clear;
  } acc_ctrl_t;

endpackage

### hdl/bpgb_smul.sv
// Bit-serial shift-add multiplier: one multiplier bit per cycle, LSB first.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module bpgb_smul #(
  parameter int AW = 44,
  parameter int BW = 22
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [AW-1:0]       a,
  input  logic [BW-1:0]       b,
  output logic                busy,
  output logic [AW+BW-1:0]    p
);

  localparam int CW = $clog2(BW + 1);

  logic [AW+BW-1:0] p_r, p_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [AW:0]      sum;

  assign sum = {1'b0, p_r[AW+BW-1:BW]} + (p_r[0] ? {1'b0, a} : (AW+1)'(0));

  always_comb begin
    p_nxt   = p_r;
    cnt_nxt = cnt_r;
    if (start) begin
      p_nxt   = {AW'(0), b};
      cnt_nxt = CW'(BW);
    end else if (cnt_r != '0) begin
      p_nxt   = {sum, p_r[BW-1:1]};
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

  assign busy = (cnt_r != '0);
  assign p    = p_r;

endmodule

### hdl/bpgb_acc.sv
// Three saturating score accumulators with halving and tight-flag compare.
// Depends on bpgb_pkg (acc_ctrl_t, term_t, OUT_W).
`timescale 1ns / 1ps

module bpgb_acc #(
  parameter int ACC_BITS = 48,
  parameter int TW       = 42
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  bpgb_pkg::acc_ctrl_t                ctrl,
  input  logic [TW-1:0]                      term,
  output logic signed [bpgb_pkg::OUT_W-1:0]  best_half,
  output logic signed [bpgb_pkg::OUT_W-1:0]  worst_half,
  output logic signed [bpgb_pkg::OUT_W-1:0]  mixed_half,
  output logic                               tight
);

  import bpgb_pkg::*;

  localparam int CMPW = (TW > ACC_BITS) ? TW : ACC_BITS;
  localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

  logic signed [ACC_BITS-1:0] best_r, best_nxt;
  logic signed [ACC_BITS-1:0] worst_r, worst_nxt;
  logic signed [ACC_BITS-1:0] mixed_r, mixed_nxt;
  logic signed [ACC_BITS-1:0] sel_sum, upd_val;
  logic [ACC_BITS-1:0]        head;
  logic                       over;
  logic signed [ACC_BITS-1:0] hb, hw, hm;

  function automatic logic signed [ACC_BITS-1:0] halve(input logic signed [ACC_BITS-1:0] s);
    logic [ACC_BITS-1:0] mag;
    logic [ACC_BITS-1:0] half;
    mag  = -s;
    half = mag >> 1;
    return signed'(-half);
  endfunction

  always_comb begin
    case (ctrl.sel)
      TERM_BEST:  sel_sum = best_r;
      TERM_WORST: sel_sum = worst_r;
      TERM_MIXED: sel_sum = mixed_r;
      default:    sel_sum = best_r;
    endcase
  end

  // distance to the negative limit: flip the sign bit of a non-positive sum
  assign head    = {~sel_sum[ACC_BITS-1], sel_sum[ACC_BITS-2:0]};
  assign over    = CMPW'(term) > CMPW'(head);
  assign upd_val = over ? ACC_MIN : (sel_sum - signed'(ACC_BITS'(term)));

  always_comb begin
    best_nxt  = best_r;
    worst_nxt = worst_r;
    mixed_nxt = mixed_r;
    if (ctrl.clear) begin
      best_nxt  = '0;
      worst_nxt = '0;
      mixed_nxt = '0;
    end else if (ctrl.upd) begin
      case (ctrl.sel)
        TERM_BEST:  best_nxt  = upd_val;
        TERM_WORST: worst_nxt = upd_val;
        TERM_MIXED: mixed_nxt = upd_val;
        default:    best_nxt  = best_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r  <= '0;
      worst_r <= '0;
      mixed_r <= '0;
    end else begin
      best_r  <= best_nxt;
      worst_r <= worst_nxt;
      mixed_r <= mixed_nxt;
    end
  end

  assign hb = halve(best_r);
  assign hw = halve(worst_r);
  assign hm = halve(mixed_r);

  assign best_half  = OUT_W'(hb);
  assign worst_half = OUT_W'(hw);
  assign mixed_half = OUT_W'(hm);
  assign tight      = (hb == hw);

endmodule

### hdl/box_pair_gaussian_bounds_top.sv
// Box pair Gaussian bounds, one dimension per transfer; uses bpgb_pkg, bpgb_smul, bpgb_acc.
// BW = max(COORD_BITS+2, 16) is the multiplier b width. in_stall holds off new transfers until
// the FSM is idle, as one bit-serial multiplier does six products per dimension in turn.
// out_valid is registered from S_EMIT after the last dimension; S_EMIT waits for out_free.
// Reset: synchronous active-low rst_n clears the FSM, sums and output valid.
`timescale 1ns / 1ps

module box_pair_gaussian_bounds_top #(
  parameter int COORD_BITS = 20,
  parameter int ACC_BITS   = 48
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [COORD_BITS-1:0]          in_part_offset,
  input  logic signed [COORD_BITS-1:0]          in_message_center,
  input  logic [COORD_BITS-2:0]                 in_message_half_range,
  input  logic signed [COORD_BITS-1:0]          in_domain_center,
  input  logic [COORD_BITS-2:0]                 in_domain_half_range,
  input  logic [bpgb_pkg::WEIGHT_W-1:0]         in_inverse_bandwidth,
  input  logic                                  in_last_dimension,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [bpgb_pkg::OUT_W-1:0]     out_best_bound,
  output logic signed [bpgb_pkg::OUT_W-1:0]     out_worst_bound,
  output logic signed [bpgb_pkg::OUT_W-1:0]     out_mixed_bound,
  output logic                                  out_bounds_tight
);

  import bpgb_pkg::*;

  localparam int TB = COORD_BITS + 2;
  localparam int BW = (TB > WEIGHT_W) ? TB : WEIGHT_W;
  localparam int AW = 2 * TB;
  localparam int PW = AW + BW;
  localparam int TW = PW - TERM_SHIFT;

  state_t state_r, state_nxt;
  term_t  term_r, term_nxt;

  logic [TB-1:0]          gap_r, sr_r;
  logic signed [TB-1:0]   dr_r;
  logic [WEIGHT_W-1:0]    w_r;
  logic                   last_r;
  logic [AW-1:0]          sq_r;

  logic signed [TB-1:0]   diff;
  logic signed [TB:0]     marg;
  logic [TB-1:0]          m;

  logic                   in_xfer, out_free;
  logic                   mul_start, mul_busy, sq_load, out_load, wt_phase;
  logic [AW-1:0]          mul_a;
  logic [BW-1:0]          mul_b;
  logic [PW-1:0]          mul_p;
  acc_ctrl_t              acc_ctrl;

  logic signed [OUT_W-1:0] best_half, worst_half, mixed_half;
  logic                    tight;

  logic signed [OUT_W-1:0] out_best_r, out_worst_r, out_mixed_r;
  logic                    out_tight_r, out_valid_r, out_valid_nxt;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign diff = TB'(in_part_offset) + TB'(in_message_center) - TB'(in_domain_center);

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      gap_r  <= diff[TB-1] ? TB'(-diff) : TB'(diff);
      sr_r   <= TB'(in_message_half_range) + TB'(in_domain_half_range);
      dr_r   <= signed'(TB'(in_message_half_range)) - signed'(TB'(in_domain_half_range));
      w_r    <= in_inverse_bandwidth;
      last_r <= in_last_dimension;
    end
    if (sq_load) begin
      sq_r <= mul_p[AW-1:0];
    end
  end

  always_comb begin
    case (term_r)
      TERM_BEST:  marg = signed'({1'b0, gap_r}) - signed'({1'b0, sr_r});
      TERM_WORST: marg = signed'({1'b0, gap_r}) + signed'({1'b0, sr_r});
      TERM_MIXED: marg = signed'({1'b0, gap_r}) + (TB+1)'(dr_r);
      default:    marg = '0;
    endcase
  end

  assign m = (!marg[TB] && (marg != '0)) ? marg[TB-1:0] : '0;

  assign wt_phase = (state_r == S_WT_GO) || (state_r == S_WT_RUN);
  assign mul_a    = wt_phase ? sq_r : AW'(m);
  assign mul_b    = wt_phase ? BW'(w_r) : BW'(m);

  bpgb_smul #(
    .AW (AW),
    .BW (BW)
  ) u_smul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .p     (mul_p)
  );

  bpgb_acc #(
    .ACC_BITS (ACC_BITS),
    .TW       (TW)
  ) u_acc (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (acc_ctrl),
    .term       (mul_p[PW-1:TERM_SHIFT]),
    .best_half  (best_half),
    .worst_half (worst_half),
    .mixed_half (mixed_half),
    .tight      (tight)
  );

  always_comb begin
    state_nxt = state_r;
    term_nxt  = term_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_SQ_GO;
          term_nxt  = TERM_BEST;
        end
      end
      S_SQ_GO: state_nxt = S_SQ_RUN;
      S_SQ_RUN: begin
        if (!mul_busy) begin
          state_nxt = S_WT_GO;
        end
      end
      S_WT_GO: state_nxt = S_WT_RUN;
      S_WT_RUN: begin
        if (!mul_busy) begin
          case (term_r)
            TERM_BEST: begin
              term_nxt  = TERM_WORST;
              state_nxt = S_SQ_GO;
            end
            TERM_WORST: begin
              term_nxt  = TERM_MIXED;
              state_nxt = S_SQ_GO;
            end
            default: state_nxt = last_r ? S_EMIT : S_IDLE;
          endcase
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    mul_start      = 1'b0;
    sq_load        = 1'b0;
    out_load       = 1'b0;
    acc_ctrl.upd   = 1'b0;
    acc_ctrl.sel   = term_r;
    acc_ctrl.clear = 1'b0;
    case (state_r)
      S_SQ_GO:  mul_start = 1'b1;
      S_SQ_RUN: sq_load = !mul_busy;
      S_WT_GO:  mul_start = 1'b1;
      S_WT_RUN: acc_ctrl.upd = !mul_busy;
      S_EMIT: begin
        out_load       = out_free;
        acc_ctrl.clear = out_free;
      end
      default: mul_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      term_r  <= TERM_BEST;
    end else begin
      state_r <= state_nxt;
      term_r  <= term_nxt;
    end
  end

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_best_r  <= best_half;
      out_worst_r <= worst_half;
      out_mixed_r <= mixed_half;
      out_tight_r <= tight;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_best_bound   = out_best_r;
  assign out_worst_bound  = out_worst_r;
  assign out_mixed_bound  = out_mixed_r;
  assign out_bounds_tight = out_tight_r;

`ifndef SYNTHESIS
  a_mul_idle_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQ_GO || state_r == S_WT_GO) |-> !mul_busy)
    else $error("multiplier restarted while busy");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_EMIT))
    else $error("result raised outside emit");

  a_bounds_nonpositive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (ACC_BITS <= OUT_W)) |->
      ((out_best_r[OUT_W-1] || out_best_r == '0) &&
       (out_worst_r[OUT_W-1] || out_worst_r == '0) &&
       (out_mixed_r[OUT_W-1] || out_mixed_r == '0)))
    else $error("positive bound");

  a_worst_lowest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (ACC_BITS <= OUT_W)) |->
      (out_worst_r <= out_best_r && out_worst_r <= out_mixed_r))
    else $error("worst bound above best or mixed");
`endif

endmodule
